[rtl/jtag_tap_navigator_shifter_core_macros.svh]
// Assertion macros shared by the TAP navigator RTL.
// No dependencies; the checking forms compile out when SYNTHESIS is defined.
`ifndef JTAG_TAP_NAVIGATOR_SHIFTER_CORE_MACROS_SVH
`define JTAG_TAP_NAVIGATOR_SHIFTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define JTN_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("JTN same-cycle check failed");
// next-cycle implication
`define JTN_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("JTN next-cycle check failed");
`else
`define JTN_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define JTN_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[rtl/jtnav_pkg.sv]
// Types, TAP state codes and the TMS microcode ROM of the TAP navigator.
// No dependencies; used by jtag_tap_navigator_shifter_core.
`timescale 1ns / 1ps

package jtnav_pkg;

   localparam int CAP_W = 32;

   typedef logic [4:0] tap_state_type;
   typedef logic [5:0] upc_type;

   localparam tap_state_type ST_UNKNOWN   = 5'd0;
   localparam tap_state_type ST_RESET     = 5'd1;
   localparam tap_state_type ST_RUNIDLE   = 5'd2;
   localparam tap_state_type ST_DRSELECT  = 5'd3;
   localparam tap_state_type ST_DRCAPTURE = 5'd4;
   localparam tap_state_type ST_DRSHIFT   = 5'd5;
   localparam tap_state_type ST_DREXIT1   = 5'd6;
   localparam tap_state_type ST_DRPAUSE   = 5'd7;
   localparam tap_state_type ST_DREXIT2   = 5'd8;
   localparam tap_state_type ST_DRUPDATE  = 5'd9;
   localparam tap_state_type ST_IRSELECT  = 5'd10;
   localparam tap_state_type ST_IRCAPTURE = 5'd11;
   localparam tap_state_type ST_IRSHIFT   = 5'd12;
   localparam tap_state_type ST_IREXIT1   = 5'd13;
   localparam tap_state_type ST_IRPAUSE   = 5'd14;
   localparam tap_state_type ST_IREXIT2   = 5'd15;
   localparam tap_state_type ST_IRUPDATE  = 5'd16;

   localparam logic OP_GOTO  = 1'b0;
   localparam logic OP_SHIFT = 1'b1;

   typedef enum logic [2:0] {
      UOP_PATH   = 3'b001,
      UOP_SHIFT  = 3'b010,
      UOP_STATUS = 3'b100
   } uop_type;

   typedef struct packed {
      uop_type uop;
      logic    tms;
      logic    last;
   } uword_type;

   typedef struct packed {
      logic    ok;
      upc_type addr;
   } nav_type;

   // ROM layout: TMS paths stored back to back, each path ending in a last
   // mark; a shorter path enters a longer one part way through.
   localparam int      ROM_DEPTH   = 57;
   localparam upc_type ADDR_STATUS = 6'd55;
   localparam upc_type ADDR_SHIFT  = 6'd56;

   function automatic uword_type rom_read(upc_type a);
      uword_type w;
      w.uop  = UOP_PATH;
      w.tms  = (a inside {[0:4], 6, 10, 11, 12, 16, 18, 21, 22, 23, 25, 28, 29,
                          32, 33, 37, 38, 40, [42:45], 47, [49:52]});
      w.last = (a inside {4, 8, 14, 19, 26, 30, 35, 41, 48, 54});
      case (a)
         ADDR_STATUS: begin
            w = '{uop: UOP_STATUS, tms: 1'b0, last: 1'b1};
         end
         ADDR_SHIFT: begin
            w = '{uop: UOP_SHIFT, tms: 1'b0, last: 1'b1};
         end
         default: begin
            // unused words past the end report status and finish
            if (a > ADDR_SHIFT) begin
               w = '{uop: UOP_STATUS, tms: 1'b0, last: 1'b1};
            end
         end
      endcase
      return w;
   endfunction

   // Entry point of the TMS path from cur to tgt; ok low when unhandled.
   function automatic nav_type nav_start(tap_state_type tgt, tap_state_type cur);
      nav_type n;
      logic    upd;
      upd    = (cur inside {ST_RUNIDLE, ST_DRUPDATE, ST_IRUPDATE});
      n.ok   = 1'b1;
      n.addr = ADDR_STATUS;
      case (tgt)
         ST_RESET: begin
            n.addr = 6'd0;
         end
         ST_RUNIDLE: begin
            if (cur == ST_RESET) n.addr = 6'd8;
            else if (cur inside {ST_DRCAPTURE, ST_DRPAUSE, ST_IRCAPTURE, ST_IRPAUSE})
               n.addr = 6'd28;
            else if (cur inside {ST_DREXIT1, ST_DREXIT2, ST_IREXIT1, ST_IREXIT2})
               n.addr = 6'd29;
            else if (cur inside {ST_DRUPDATE, ST_IRUPDATE}) n.addr = 6'd8;
            else n.ok = 1'b0;
         end
         ST_DRCAPTURE: begin
            if (cur == ST_RESET) n.addr = 6'd17;
            else if (upd) n.addr = 6'd18;
            else if (cur == ST_DRSELECT) n.addr = 6'd8;
            else n.ok = 1'b0;
         end
         ST_DRSHIFT: begin
            if (cur == ST_RESET) n.addr = 6'd5;
            else if (upd) n.addr = 6'd6;
            else if (cur == ST_DRSELECT) n.addr = 6'd7;
            else if (cur == ST_DRCAPTURE) n.addr = 6'd8;
            else if (cur == ST_DRPAUSE) n.addr = 6'd18;
            else if (cur == ST_DREXIT2) n.addr = 6'd8;
            else if (cur == ST_IRSELECT) n.addr = 6'd9;
            else if (cur inside {ST_IRCAPTURE, ST_IRPAUSE}) n.addr = 6'd10;
            else if (cur inside {ST_IREXIT1, ST_IREXIT2}) n.addr = 6'd11;
            else n.ok = 1'b0;
         end
         ST_DRPAUSE: begin
            if (cur == ST_RESET) n.addr = 6'd15;
            else if (upd) n.addr = 6'd16;
            else if (cur == ST_DRSELECT) n.addr = 6'd17;
            else if (cur == ST_DRCAPTURE) n.addr = 6'd18;
            else if (cur == ST_DREXIT1) n.addr = 6'd19;
            else if (cur == ST_IRSELECT) n.addr = 6'd20;
            else if (cur inside {ST_IRCAPTURE, ST_IRPAUSE}) n.addr = 6'd21;
            else if (cur inside {ST_IREXIT1, ST_IREXIT2}) n.addr = 6'd22;
            else n.ok = 1'b0;
         end
         ST_DRUPDATE: begin
            if (cur inside {ST_DRCAPTURE, ST_DRPAUSE}) n.addr = 6'd3;
            else if (cur inside {ST_DREXIT1, ST_DREXIT2}) n.addr = 6'd4;
            else n.ok = 1'b0;
         end
         ST_IRCAPTURE: begin
            if (cur == ST_RESET) n.addr = 6'd27;
            else if (upd) n.addr = 6'd28;
            else if (cur == ST_DRSELECT) n.addr = 6'd29;
            else if (cur == ST_IRSELECT) n.addr = 6'd30;
            else n.ok = 1'b0;
         end
         ST_IRSHIFT: begin
            if (cur == ST_RESET) n.addr = 6'd31;
            else if (upd) n.addr = 6'd32;
            else if (cur == ST_DRSELECT) n.addr = 6'd33;
            else if (cur == ST_IRSELECT) n.addr = 6'd34;
            else if (cur == ST_IRCAPTURE) n.addr = 6'd35;
            else if (cur == ST_IRPAUSE) n.addr = 6'd18;
            else if (cur == ST_IREXIT2) n.addr = 6'd35;
            else if (cur inside {ST_DRCAPTURE, ST_DRPAUSE}) n.addr = 6'd49;
            else if (cur inside {ST_DREXIT1, ST_DREXIT2}) n.addr = 6'd50;
            else n.ok = 1'b0;
         end
         ST_IRPAUSE: begin
            if (cur == ST_RESET) n.addr = 6'd36;
            else if (upd) n.addr = 6'd37;
            else if (cur == ST_DRSELECT) n.addr = 6'd38;
            else if (cur == ST_IRSELECT) n.addr = 6'd39;
            else if (cur == ST_IRCAPTURE) n.addr = 6'd40;
            else if (cur == ST_IREXIT1) n.addr = 6'd41;
            else if (cur inside {ST_DRCAPTURE, ST_DRPAUSE}) n.addr = 6'd42;
            else if (cur inside {ST_DREXIT1, ST_DREXIT2}) n.addr = 6'd43;
            else n.ok = 1'b0;
         end
         ST_IRUPDATE: begin
            if (cur inside {ST_IRCAPTURE, ST_IRPAUSE}) n.addr = 6'd3;
            else if (cur inside {ST_IREXIT1, ST_IREXIT2}) n.addr = 6'd4;
            else n.ok = 1'b0;
         end
         default: begin
            n.ok = 1'b0;
         end
      endcase
      if (!n.ok) n.addr = ADDR_STATUS;
      return n;
   endfunction

endpackage

[rtl/jtag_tap_navigator_shifter_core.sv]
// JTAG TAP master core: state tracker, microcoded TMS navigator, bit shifter.
// Depends on jtnav_pkg and jtag_tap_navigator_shifter_core_macros.svh.
//
// Usage: each request on req_* is either a goto (operation 0) or one shift bit
// (operation 1). A goto produces one response per TCK pulse along a fixed TMS
// path from the tracked state to target_state (1 to 7 pulses), or one status
// response with rsp_clock_pulse low when no path is known; a shift bit gives
// one response with the TDI/TMS levels and the updated shift register.
// rsp_last marks the final response of each request.
// Timing: a request loads the program counter and sets busy; the first ROM
// word is then read and its response registered in the output register;
// further responses follow one per cycle, one microcode ROM word each,
// unless rsp_stall holds them. req_stall is high while the program runs.
// A response stalled by rsp_stall holds in the output register and the
// program waits on it; the next request can be taken while the final
// response is still held. Reset clears the tracked state to unknown, the
// shift register to zero and drops all pending work.
`timescale 1ns / 1ps
`include "jtag_tap_navigator_shifter_core_macros.svh"

module jtag_tap_navigator_shifter_core #(
   parameter int SHIFT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [4:0]  req_target_state,
   input  logic        req_load_first,
   input  logic [31:0] req_load_word,
   input  logic [5:0]  req_bit_count,
   input  logic        req_tdi_zero,
   input  logic        req_tdo_sample,
   input  logic        req_final_bit,
   input  logic        req_exit_after,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_clock_pulse,
   output logic        rsp_tms_level,
   output logic        rsp_tdi_level,
   output logic [4:0]  rsp_tap_state_now,
   output logic [31:0] rsp_captured_word,
   output logic        rsp_last
);

   localparam int IDX_W = $clog2(SHIFT_WIDTH);

   logic                       busy_ff, busy_in;
   jtnav_pkg::upc_type         upc_ff, upc_in;
   jtnav_pkg::tap_state_type   tap_state_ff, tap_state_in;
   logic [SHIFT_WIDTH-1:0]     shift_ff, shift_in;
   logic                       tms_shift_ff, tms_shift_in;
   logic                       tdi_shift_ff, tdi_shift_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_clock_pulse_ff, rsp_clock_pulse_in;
   logic                       rsp_tms_ff, rsp_tms_in;
   logic                       rsp_tdi_ff, rsp_tdi_in;
   jtnav_pkg::tap_state_type   rsp_state_ff, rsp_state_in;
   logic [jtnav_pkg::CAP_W-1:0] rsp_word_ff, rsp_word_in;
   logic                       rsp_last_ff, rsp_last_in;

   jtnav_pkg::uword_type       uword;
   jtnav_pkg::nav_type         nav;
   logic                       req_accept;
   logic                       issue;
   logic [6:0]                 bits_eff;
   logic [6:0]                 idx_wide;
   logic [IDX_W-1:0]           idx;
   logic [SHIFT_WIDTH-1:0]     base;
   logic [SHIFT_WIDTH-1:0]     shifted;

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign issue      = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign uword      = jtnav_pkg::rom_read(upc_ff);
   assign nav        = jtnav_pkg::nav_start(req_target_state, tap_state_ff);

   // shift datapath: clamp length, load, shift right, insert TDO
   always_comb begin
      bits_eff = {1'b0, req_bit_count};
      if (bits_eff == 7'd0) begin
         bits_eff = 7'd1;
      end else if (bits_eff > 7'(SHIFT_WIDTH)) begin
         bits_eff = 7'(SHIFT_WIDTH);
      end
      idx_wide = bits_eff - 7'd1;
      idx      = idx_wide[IDX_W-1:0];
      base     = req_load_first ? SHIFT_WIDTH'(req_load_word) : shift_ff;
      shifted      = base >> 1;
      shifted[idx] = req_tdo_sample;
   end

   always_comb begin
      busy_in      = busy_ff;
      upc_in       = upc_ff;
      tap_state_in = tap_state_ff;
      shift_in     = shift_ff;
      tms_shift_in = tms_shift_ff;
      tdi_shift_in = tdi_shift_ff;

      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_clock_pulse_in = rsp_clock_pulse_ff;
      rsp_tms_in         = rsp_tms_ff;
      rsp_tdi_in         = rsp_tdi_ff;
      rsp_state_in       = rsp_state_ff;
      rsp_word_in        = rsp_word_ff;
      rsp_last_in        = rsp_last_ff;

      if (req_accept) begin
         busy_in = 1'b1;
         if (req_operation == jtnav_pkg::OP_SHIFT) begin
            upc_in       = jtnav_pkg::ADDR_SHIFT;
            shift_in     = shifted;
            tdi_shift_in = req_tdi_zero ? 1'b0 : base[0];
            tms_shift_in = req_final_bit && req_exit_after;
            if (req_final_bit && req_exit_after) begin
               case (tap_state_ff)
                  jtnav_pkg::ST_DRSHIFT: tap_state_in = jtnav_pkg::ST_DREXIT1;
                  jtnav_pkg::ST_DRPAUSE: tap_state_in = jtnav_pkg::ST_DREXIT2;
                  jtnav_pkg::ST_IRSHIFT: tap_state_in = jtnav_pkg::ST_IREXIT1;
                  jtnav_pkg::ST_IRPAUSE: tap_state_in = jtnav_pkg::ST_IREXIT2;
                  default:               tap_state_in = tap_state_ff;
               endcase
            end
         end else begin
            upc_in = nav.addr;
            if (nav.ok) tap_state_in = req_target_state;
         end
      end

      // step the program: one control word per response
      if (issue) begin
         rsp_valid_in       = 1'b1;
         rsp_clock_pulse_in = (uword.uop != jtnav_pkg::UOP_STATUS);
         rsp_tms_in         = (uword.uop == jtnav_pkg::UOP_SHIFT) ? tms_shift_ff : uword.tms;
         rsp_tdi_in         = (uword.uop == jtnav_pkg::UOP_SHIFT) ? tdi_shift_ff : 1'b0;
         rsp_state_in       = tap_state_ff;
         rsp_word_in        = jtnav_pkg::CAP_W'(shift_ff);
         rsp_last_in        = uword.last;
         upc_in             = upc_ff + 6'd1;
         if (uword.last) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tap_state_ff <= jtnav_pkg::ST_UNKNOWN;
         shift_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         tap_state_ff <= tap_state_in;
         shift_ff     <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      upc_ff             <= upc_in;
      tms_shift_ff       <= tms_shift_in;
      tdi_shift_ff       <= tdi_shift_in;
      rsp_clock_pulse_ff <= rsp_clock_pulse_in;
      rsp_tms_ff         <= rsp_tms_in;
      rsp_tdi_ff         <= rsp_tdi_in;
      rsp_state_ff       <= rsp_state_in;
      rsp_word_ff        <= rsp_word_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_clock_pulse   = rsp_clock_pulse_ff;
   assign rsp_tms_level     = rsp_tms_ff;
   assign rsp_tdi_level     = rsp_tdi_ff;
   assign rsp_tap_state_now = rsp_state_ff;
   assign rsp_captured_word = rsp_word_ff;
   assign rsp_last          = rsp_last_ff;

   `JTN_ASSERT_IMPLY(a_status_quiet, clock, reset, rsp_valid_ff && !rsp_clock_pulse_ff,
      rsp_last_ff && !rsp_tms_ff && !rsp_tdi_ff)
   `JTN_ASSERT_NEXT(a_last_ends_program, clock, reset, issue && uword.last, !busy_ff)
   `JTN_ASSERT_IMPLY(a_upc_in_rom, clock, reset, busy_ff,
      upc_ff < 6'(jtnav_pkg::ROM_DEPTH))
   `JTN_ASSERT_IMPLY(a_state_legal, clock, reset, 1'b1,
      tap_state_ff <= jtnav_pkg::ST_IRUPDATE)

endmodule
